/* hw/rtl/prim_pkg.sv */
// prim_pkg: shared constants and types for the trial-division primality tester.
// Used by prim_div and primality_test_trial_division_top. No dependencies.
package prim_pkg;

    // default width of the tested number
    localparam int PRIM_WIDTH_DEFAULT = 32;

    // 6k +/- 1 wheel
    localparam int FIRST_DIVISOR = 5;
    localparam int PAIR_GAP      = 2;
    localparam int WHEEL_STEP    = 6;
    localparam int SMALL_PRIME   = 3;

    // divider status back to the sequencer
    typedef struct packed {
        logic done;      // one-cycle pulse, quotient and remainder final
        logic rem_zero;  // remainder is zero
    } div_status_t;

endpackage

/* hw/rtl/prim_div.sv */
// prim_div: iterative restoring divider, one quotient bit per cycle.
// Depends on prim_pkg (div_status_t).
module prim_div #(
    parameter int WIDTH = prim_pkg::PRIM_WIDTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [WIDTH-1:0]       dividend,
    input  logic [WIDTH-1:0]       divisor,
    output prim_pkg::div_status_t  stat,
    output logic [WIDTH-1:0]       quotient
);
    import prim_pkg::*;

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [WIDTH-1:0] q_reg, q_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] dvs_reg, dvs_next;

    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   diff;
    logic             ge;

    // one restoring step: shift in next dividend bit, try subtract
    assign shifted = {rem_reg, q_reg[WIDTH-1]};
    assign ge      = (shifted >= {1'b0, dvs_reg});
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[WIDTH-2:0], ge};
            rem_next = ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.done     = done_reg;
    assign stat.rem_zero = (rem_reg == '0);
    assign quotient      = q_reg;

endmodule

/* hw/rtl/primality_test_trial_division_top.sv */
// Trial-division primality tester (6k +/- 1 wheel), one shared divider.
// Path from input transfer to out_valid: 0..3 and even numbers go straight to ST_DONE; otherwise
// one division by 3 runs on the shared divider, then two divisions per wheel step.
// Worst case at WIDTH=32 (prime near 2^32): 21846 divisions.
// Throughput: one item at a time, set by the bit-serial divider; in_ready only when idle.
// Reset: rst_n asynchronous active low clears sequencer, divider control and output valid.
module primality_test_trial_division_top #(
    parameter int WIDTH = prim_pkg::PRIM_WIDTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] number,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        is_prime
);
    import prim_pkg::*;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for an input transfer
    localparam logic [2:0] ST_DIV3 = 3'd1;  // n / 3 running
    localparam logic [2:0] ST_DIVD = 3'd2;  // n / d running (also gives loop bound)
    localparam logic [2:0] ST_DIVE = 3'd3;  // n / (d+2) running
    localparam logic [2:0] ST_DONE = 3'd4;  // verdict waiting for the output register

    logic [2:0]       state_reg, state_next;
    logic [WIDTH-1:0] n_reg, n_next;
    logic [WIDTH-1:0] d_reg, d_next;
    logic             res_reg, res_next;
    logic             out_valid_reg, out_valid_next;
    logic             is_prime_reg, is_prime_next;

    logic [WIDTH-1:0] n_in;
    logic             in_xfer;
    logic             slot_free;

    logic             div_start;
    logic [WIDTH-1:0] div_dividend;
    logic [WIDTH-1:0] div_divisor;
    div_status_t      div_stat;
    logic [WIDTH-1:0] div_quot;

    // only the low WIDTH bits of the number take part; above 32 bits it is zero-extended
    generate
        if (WIDTH <= 32)
        begin : g_narrow
            assign n_in = number[WIDTH-1:0];
        end
        else
        begin : g_wide
            assign n_in = {{(WIDTH-32){1'b0}}, number};
        end
    endgenerate

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    // dividend straight from the port on the accepting cycle, from n_reg after
    assign div_dividend = (state_reg == ST_IDLE) ? n_in : n_reg;

    always_comb
    begin
        state_next   = state_reg;
        n_next       = n_reg;
        d_next       = d_reg;
        res_next     = res_reg;
        div_start    = 1'b0;
        div_divisor  = WIDTH'(SMALL_PRIME);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    n_next = n_in;
                    if (n_in == WIDTH'(1))
                    begin
                        res_next   = 1'b0;
                        state_next = ST_DONE;
                    end
                    else if (n_in == WIDTH'(PAIR_GAP) || n_in == WIDTH'(SMALL_PRIME))
                    begin
                        res_next   = 1'b1;
                        state_next = ST_DONE;
                    end
                    else if (!n_in[0])
                    begin
                        // even, zero included
                        res_next   = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        div_start   = 1'b1;
                        div_divisor = WIDTH'(SMALL_PRIME);
                        state_next  = ST_DIV3;
                    end
                end
            end
            ST_DIV3:
            begin
                if (div_stat.done)
                begin
                    if (div_stat.rem_zero)
                    begin
                        res_next   = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        d_next      = WIDTH'(FIRST_DIVISOR);
                        div_start   = 1'b1;
                        div_divisor = WIDTH'(FIRST_DIVISOR);
                        state_next  = ST_DIVD;
                    end
                end
            end
            ST_DIVD:
            begin
                if (div_stat.done)
                begin
                    if (div_quot < d_reg)
                    begin
                        // d*d > n: no divisor left to try
                        res_next   = 1'b1;
                        state_next = ST_DONE;
                    end
                    else if (div_stat.rem_zero)
                    begin
                        res_next   = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        div_start   = 1'b1;
                        div_divisor = d_reg + WIDTH'(PAIR_GAP);
                        state_next  = ST_DIVE;
                    end
                end
            end
            ST_DIVE:
            begin
                if (div_stat.done)
                begin
                    if (div_stat.rem_zero)
                    begin
                        res_next   = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        // d stays below sqrt(n), so d+6 cannot wrap
                        d_next      = d_reg + WIDTH'(WHEEL_STEP);
                        div_start   = 1'b1;
                        div_divisor = d_reg + WIDTH'(WHEEL_STEP);
                        state_next  = ST_DIVD;
                    end
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register: loaded from the verdict, held until the transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        is_prime_next  = is_prime_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (state_reg == ST_DONE && slot_free)
        begin
            out_valid_next = 1'b1;
            is_prime_next  = res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        d_reg        <= d_next;
        res_reg      <= res_next;
        is_prime_reg <= is_prime_next;
    end

    prim_div #(
        .WIDTH (WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    assign out_valid = out_valid_reg;
    assign is_prime  = is_prime_reg;

endmodule

/* bench/primality_test_trial_division_top_tb.sv */
`timescale 1ns / 1ps
// Testbench for primality_test_trial_division_top: drives numbers, predicts the prime flag.
// Depends on the RTL top level and prim_pkg only; reads nothing at run time.
module primality_test_trial_division_top_tb;

    // Width of the tested number; the port is always 32 bits wide.
    localparam int TEST_WIDTH  = 32;
    localparam int WHEEL_FIRST = 5;
    localparam int WHEEL_GAP   = 2;
    localparam int WHEEL_STEP  = 6;
    localparam int ITEMS_PER_PHASE = 19;
    // A 32-bit prime near the top is the costliest item by far and each random item
    // costs much less, so 10M leaves plenty of room.
    localparam int CYCLE_LIMIT = 10_000_000;
    localparam int DRAIN_CYCLES = 50;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] number;
    logic        out_valid;
    logic        out_ready;
    logic        is_prime;

    logic [31:0] pending_numbers[$];   // numbers waiting to be driven
    logic        expected_flags[$];    // prime flags owed by the block, oldest first
    logic        number_taken;         // input transfer at the last rising edge
    logic        want_flag;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          failures;
    int          cycle_count;

    primality_test_trial_division_top #(
        .WIDTH(TEST_WIDTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .number   (number),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .is_prime (is_prime)
    );

    always #1 clk = ~clk;

    // Prime test by the 6k +/- 1 wheel. The square bound is taken as d <= n / d so
    // that nothing overflows, whatever the width.
    function automatic logic prime_by_trial(input logic [31:0] value);
        logic [63:0] n;
        logic [63:0] d;
        n = {32'd0, value} & ((64'd1 << TEST_WIDTH) - 64'd1);
        if (n == 64'd1)
            return 1'b0;
        if (n == 64'd2 || n == 64'd3)
            return 1'b1;
        if (n % 64'd2 == 64'd0 || n % 64'd3 == 64'd0)
            return 1'b0;
        for (d = 64'(WHEEL_FIRST); d <= n / d; d += 64'(WHEEL_STEP))
        begin
            if (n % d == 64'd0 || n % (d + 64'(WHEEL_GAP)) == 64'd0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Random number, kept cheap for the block: large values always carry a small
    // factor, so only small values ever run the wheel for long.
    function automatic logic [31:0] pick_number();
        logic [31:0] factor;
        int          kind;
        kind = $urandom_range(0, 9);
        if (kind < 4)
            return $urandom_range(0, 32'h0000_FFFF);
        if (kind < 6)
            return $urandom_range(0, 32'h000F_FFFF) | 32'd1;
        if (kind < 8)
        begin
            // cofactor from 5 to 255, times a random multiplier that still fits
            factor = $urandom_range(WHEEL_FIRST, 255);
            return factor * $urandom_range(1, 32'hFFFF_FFFF / factor);
        end
        if (kind == 8)
            return $urandom & ~32'd1;
        return 32'd3 * $urandom_range(0, 32'd1431655765);
    endfunction

    // Driver: moves at the falling edge. Valid is held with its number until the
    // transfer is seen; out_ready is rolled afresh every cycle.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            out_ready <= 1'b0;
        end
        else
        begin
            if (in_valid && !number_taken)
                ; // still waiting for the transfer
            else if (pending_numbers.size() > 0 &&
                     $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                number   <= pending_numbers.pop_front();
            end
            else
                in_valid <= 1'b0;
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Monitor: samples both channels at the rising edge. An accepted number owes
    // one flag; every result transfer is checked against the oldest one owed.
    always @(posedge clk)
    begin
        number_taken = rst_n && in_valid && in_ready;
        if (number_taken)
            expected_flags.push_back(prime_by_trial(number));
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_flags.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual is_prime=%b",
                         $time, is_prime);
                failures++;
            end
            else
            begin
                want_flag = expected_flags.pop_front();
                if (is_prime !== want_flag)
                begin
                    $display("%0t: is_prime mismatch, expected %b, actual %b",
                             $time, want_flag, is_prime);
                    failures++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Sender has nothing left and every flag has come back.
    task automatic wait_drained();
        while (pending_numbers.size() > 0 || in_valid || expected_flags.size() > 0)
            @(posedge clk);
    endtask

    // Random phase: the sender stops short of the next phase until the block has
    // answered everything, so each phase starts from an idle block.
    task automatic run_phase(input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (ITEMS_PER_PHASE)
            pending_numbers.push_back(pick_number());
        wait_drained();
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        number         = '0;
        out_ready      = 1'b0;
        number_taken   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        failures       = 0;
        cycle_count    = 0;

        repeat (11) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // Directed: zero, one, the small primes, the wheel boundaries where d*d or
        // (d+2)^2 equals the number, and the top of the 32-bit range.
        pending_numbers = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7,
                            32'd9, 32'd25, 32'd35, 32'd49, 32'd121, 32'd143, 32'd169,
                            32'd1018081, 32'd1026169, 32'd65521, 32'd65537,
                            32'd1000003, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000,
                            32'hFFFE_0001, 32'd4294967291};
        wait_drained();

        // Random: full rate, sender idling, receiver stalling, then light idling on both.
        run_phase(0, 0);
        run_phase(84, 0);
        run_phase(0, 84);
        run_phase(14, 14);

        // Let any stray result show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
